// ===== rtl/anbc_pkg.sv =====
`default_nettype none
package anbc_pkg;

    localparam logic [7:0] ChNl    = 8'd10;
    localparam logic [7:0] ChZero  = 8'd48;
    localparam logic [7:0] ChA     = 8'd97;
    localparam logic [7:0] ChMinus = 8'd45;
    localparam logic [7:0] ChX     = 8'd120;
    localparam logic [7:0] ChB     = 8'd98;

    // entry handed from the parser to the formatter
    typedef struct packed {
        logic [31:0] word;
    } anbc_job_t;

    typedef enum logic [3:0] {
        FMT_IDLE,
        FMT_BIN_PFX,
        FMT_BIN,
        FMT_DEC1_CONV,
        FMT_DEC1_OUT,
        FMT_HEX_PFX,
        FMT_HEX,
        FMT_DEC2_CONV,
        FMT_DEC2_OUT
    } fmt_state_t;

    // lowercase hex character of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10)
        begin
            r = ChZero + {4'd0, d};
        end
        else
        begin
            r = ChA + {4'd0, d} - 8'd10;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/anbc_parser.sv =====
`default_nettype none
module anbc_parser
    import anbc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire logic [7:0] in_byte,
    output logic           job_valid,
    input  wire logic      job_stall,
    output anbc_job_t      job
);

    logic [31:0] acc_reg;
    logic        minus_reg;
    logic        hex_reg;
    logic [4:0]  pos_reg;
    logic        full_reg;
    anbc_job_t   job_reg;

    logic        take;
    logic        is_nl;
    logic [31:0] digit;
    logic [31:0] word;

    // stall only on a newline with the queue slot occupied
    assign is_nl    = (in_byte == ChNl);
    assign in_stall = is_nl && full_reg && job_stall;
    assign take     = in_valid && !in_stall;

    assign job_valid = full_reg;
    assign job       = job_reg;

    always_comb
    begin
        if (in_byte <= 8'd57)
        begin
            digit = {24'd0, in_byte} - 32'd48;
        end
        else
        begin
            digit = {24'd0, in_byte} - 32'd87;
        end
        word = (!hex_reg && minus_reg) ? (32'd0 - acc_reg) : acc_reg;
    end

    // parse state and the one-entry queue toward the formatter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            minus_reg <= 1'b0;
            hex_reg   <= 1'b0;
            pos_reg   <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            if (take && is_nl)
            begin
                full_reg <= 1'b1;
            end
            else if (full_reg && !job_stall)
            begin
                full_reg <= 1'b0;
            end
            if (take)
            begin
                if (is_nl)
                begin
                    job_reg.word <= word;
                    acc_reg      <= '0;
                    minus_reg    <= 1'b0;
                    hex_reg      <= 1'b0;
                    pos_reg      <= '0;
                end
                else
                begin
                    priority if (pos_reg == 5'd0 && in_byte == ChMinus)
                    begin
                        minus_reg <= 1'b1;
                    end
                    else if (pos_reg == 5'd1 && in_byte == ChX)
                    begin
                        hex_reg <= 1'b1;
                        acc_reg <= '0;
                    end
                    else if (hex_reg)
                    begin
                        acc_reg <= {acc_reg[27:0], 4'd0} + digit;
                    end
                    else
                    begin
                        acc_reg <= {acc_reg[28:0], 3'd0} + {acc_reg[30:0], 1'b0}
                                   + {24'd0, in_byte} - 32'd48;
                    end
                    if (pos_reg != 5'd31)
                    begin
                        pos_reg <= pos_reg + 5'd1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/anbc_formatter.sv =====
`default_nettype none
module anbc_formatter
    import anbc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       job_valid,
    output logic            job_stall,
    input  wire anbc_job_t  job,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      first_char,
    output logic [7:0]      second_char,
    output logic            second_valid,
    output logic            last
);

    fmt_state_t  state_reg, state_next;
    logic [31:0] word_reg;
    logic [31:0] val_reg;
    logic [5:0]  idx_reg;
    // decimal digits, least significant first; ten digits max
    logic [3:0]  dig_reg [10];
    logic [3:0]  ndig_reg;
    logic        neg_reg;
    logic        sign_done_reg;

    // pending first character of a pair
    logic [7:0]  pend_reg;
    logic        pend_valid_reg;

    // output register
    logic [7:0]  o1_reg, o2_reg;
    logic        o2v_reg, olast_reg, ovalid_reg;

    logic        can_emit;
    logic        ch_valid;
    logic [7:0]  ch;
    logic        ch_final;
    logic [5:0]  top_bit;
    logic [2:0]  top_nib;
    logic [31:0] swapped;
    logic [31:0] quo;
    logic [3:0]  rem;

    assign can_emit  = !ovalid_reg || !out_stall;
    assign job_stall = (state_reg != FMT_IDLE);
    assign out_valid    = ovalid_reg;
    assign first_char   = o1_reg;
    assign second_char  = o2_reg;
    assign second_valid = o2v_reg;
    assign last         = olast_reg;

    assign swapped = {word_reg[7:0], word_reg[15:8], word_reg[23:16], word_reg[31:24]};

    // divide by ten: one reciprocal multiply, remainder by multiplying back
    always_comb
    begin
        logic [63:0] m;
        logic [31:0] q0;
        logic [31:0] r0;
        m    = {32'd0, val_reg} * 64'hCCCCCCCD;
        q0   = {3'd0, m[63:35]};
        r0   = val_reg - ((q0 << 3) + (q0 << 1));
        quo  = q0;
        rem  = r0[3:0];
    end

    // find highest set bit and highest nonzero nibble
    always_comb
    begin
        top_bit = 6'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (word_reg[i])
            begin
                top_bit = 6'(i);
            end
        end
        top_nib = 3'd0;
        for (int j = 0; j < 8; j++)
        begin
            if (word_reg[4*j +: 4] != 4'd0)
            begin
                top_nib = 3'(j);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FMT_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = FMT_BIN_PFX;
                end
            end
            FMT_BIN_PFX:
            begin
                if (can_emit && idx_reg == 6'd1)
                begin
                    state_next = FMT_BIN;
                end
            end
            FMT_BIN:
            begin
                if (can_emit && idx_reg == 6'd63)
                begin
                    state_next = FMT_DEC1_CONV;
                end
            end
            FMT_DEC1_CONV:
            begin
                if (val_reg < 32'd10)
                begin
                    state_next = FMT_DEC1_OUT;
                end
            end
            FMT_DEC1_OUT:
            begin
                if (can_emit && sign_done_reg && ndig_reg == 4'd15)
                begin
                    state_next = FMT_HEX_PFX;
                end
            end
            FMT_HEX_PFX:
            begin
                if (can_emit && idx_reg == 6'd1)
                begin
                    state_next = FMT_HEX;
                end
            end
            FMT_HEX:
            begin
                if (can_emit && idx_reg == 6'd63)
                begin
                    state_next = FMT_DEC2_CONV;
                end
            end
            FMT_DEC2_CONV:
            begin
                if (val_reg < 32'd10)
                begin
                    state_next = FMT_DEC2_OUT;
                end
            end
            FMT_DEC2_OUT:
            begin
                if (can_emit && sign_done_reg && ndig_reg == 4'd15)
                begin
                    state_next = FMT_IDLE;
                end
            end
            default:
            begin
                state_next = FMT_IDLE;
            end
        endcase
    end

    // character produced this cycle
    always_comb
    begin
        ch_valid = 1'b0;
        ch       = ChNl;
        ch_final = 1'b0;
        unique case (state_reg)
            FMT_BIN_PFX, FMT_HEX_PFX:
            begin
                ch_valid = 1'b1;
                if (idx_reg == 6'd0)
                begin
                    ch = ChZero;
                end
                else if (state_reg == FMT_BIN_PFX)
                begin
                    ch = ChB;
                end
                else
                begin
                    ch = ChX;
                end
            end
            FMT_BIN:
            begin
                ch_valid = 1'b1;
                ch = (idx_reg == 6'd63) ? ChNl : (ChZero + {7'd0, word_reg[idx_reg[4:0]]});
            end
            FMT_HEX:
            begin
                ch_valid = 1'b1;
                ch = (idx_reg == 6'd63) ? ChNl : hex_char(word_reg[4*idx_reg[2:0] +: 4]);
            end
            FMT_DEC1_OUT, FMT_DEC2_OUT:
            begin
                ch_valid = 1'b1;
                if (!sign_done_reg)
                begin
                    ch = ChMinus;
                end
                else if (ndig_reg == 4'd15)
                begin
                    ch = ChNl;
                    ch_final = (state_reg == FMT_DEC2_OUT);
                end
                else
                begin
                    ch = ChZero + {4'd0, dig_reg[ndig_reg]};
                end
            end
            FMT_IDLE, FMT_DEC1_CONV, FMT_DEC2_CONV:
            begin
                ch_valid = 1'b0;
            end
            default:
            begin
                ch_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FMT_IDLE;
            pend_valid_reg <= 1'b0;
            ovalid_reg     <= 1'b0;
            idx_reg        <= '0;
            ndig_reg       <= '0;
            sign_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // load a new result or drop the one just transferred
            if (ch_valid && can_emit && (pend_valid_reg || ch_final))
            begin
                ovalid_reg <= 1'b1;
            end
            else if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end

            // pair characters into results
            if (ch_valid && can_emit)
            begin
                if (pend_valid_reg)
                begin
                    o1_reg         <= pend_reg;
                    o2_reg         <= ch;
                    o2v_reg        <= 1'b1;
                    olast_reg      <= ch_final;
                    pend_valid_reg <= 1'b0;
                end
                else if (ch_final)
                begin
                    o1_reg     <= ch;
                    o2_reg     <= 8'd0;
                    o2v_reg    <= 1'b0;
                    olast_reg  <= 1'b1;
                end
                else
                begin
                    pend_reg       <= ch;
                    pend_valid_reg <= 1'b1;
                end
            end

            // sequencing of the per-line index and the decimal digit stack
            unique case (state_reg)
                FMT_IDLE:
                begin
                    if (job_valid)
                    begin
                        word_reg <= job.word;
                        idx_reg  <= '0;
                    end
                end
                FMT_BIN_PFX, FMT_HEX_PFX:
                begin
                    if (can_emit)
                    begin
                        if (idx_reg == 6'd1)
                        begin
                            idx_reg <= (state_reg == FMT_BIN_PFX) ? top_bit : {3'd0, top_nib};
                        end
                        else
                        begin
                            idx_reg <= 6'd1;
                        end
                    end
                end
                FMT_BIN, FMT_HEX:
                begin
                    if (can_emit)
                    begin
                        if (idx_reg == 6'd63)
                        begin
                            neg_reg  <= (state_reg == FMT_BIN) ? word_reg[31] : swapped[31];
                            val_reg  <= (state_reg == FMT_BIN)
                                        ? (word_reg[31] ? 32'd0 - word_reg : word_reg)
                                        : (swapped[31] ? 32'd0 - swapped : swapped);
                            ndig_reg <= '0;
                        end
                        else if (idx_reg == 6'd0)
                        begin
                            idx_reg <= 6'd63;
                        end
                        else
                        begin
                            idx_reg <= idx_reg - 6'd1;
                        end
                    end
                end
                FMT_DEC1_CONV, FMT_DEC2_CONV:
                begin
                    dig_reg[ndig_reg] <= rem;
                    val_reg <= quo;
                    if (val_reg >= 32'd10)
                    begin
                        ndig_reg <= ndig_reg + 4'd1;
                    end
                    sign_done_reg <= !neg_reg;
                end
                FMT_DEC1_OUT, FMT_DEC2_OUT:
                begin
                    if (can_emit)
                    begin
                        if (!sign_done_reg)
                        begin
                            sign_done_reg <= 1'b1;
                        end
                        else if (ndig_reg == 4'd15)
                        begin
                            idx_reg <= '0;
                        end
                        else if (ndig_reg == 4'd0)
                        begin
                            ndig_reg <= 4'd15;
                        end
                        else
                        begin
                            ndig_reg <= ndig_reg - 4'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ascii_number_base_converter_core.sv =====
// Reads one ASCII line a byte per transfer (decimal with optional leading
// minus, or 0x-prefixed lowercase hex) and, on the newline, emits binary,
// signed decimal, hex and byte-swapped signed decimal lines as character
// pairs, last set on the final result. Non-newline bytes are never stalled.
// A newline hands its word through a one-entry queue to the formatter, which
// picks it up from the queue register, emits one character per cycle while
// the output is not stalled and produces the decimal digits one at a time in
// the divide-by-ten unit. A second line can be parsed while the formatter
// still works on the first; only its newline stalls while the queue entry is
// still occupied.
`default_nettype none
module ascii_number_base_converter_core
    import anbc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      first_char,
    output logic [7:0]      second_char,
    output logic            second_valid,
    output logic            last
);

    logic      job_valid;
    logic      job_stall;
    anbc_job_t job;

    anbc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .job_valid (job_valid),
        .job_stall (job_stall),
        .job       (job)
    );

    anbc_formatter u_formatter (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_stall    (job_stall),
        .job          (job),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .first_char   (first_char),
        .second_char  (second_char),
        .second_valid (second_valid),
        .last         (last)
    );

endmodule
`default_nettype wire

// ===== rtl/anbc_checker.sv =====
`default_nettype none
module anbc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [7:0] in_byte,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] first_char,
    input wire logic [7:0] second_char,
    input wire logic       second_valid,
    input wire logic       last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(first_char) && $stable(last))
        else $error("stalled result changed");

    // a single-character result is always the final one
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !second_valid |-> last)
        else $error("short result before end");

    // an empty second slot carries zero
    a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !second_valid |-> second_char == 8'd0)
        else $error("second_char not zero");

    // the final result ends in a newline
    a_last_nl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> (second_valid ? second_char : first_char) == 8'd10)
        else $error("final result without newline");

    // ordinary bytes never stall
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_byte != 8'd10 |-> !in_stall)
        else $error("non-newline byte stalled");

endmodule

bind ascii_number_base_converter_core anbc_checker u_anbc_checker (.*);
`default_nettype wire
